[src/aps_pkg.sv]
package aps_pkg;

  localparam int COORD_W = 24;
  localparam int SCALE_W = 16;
  localparam int CFG_IDX_W = 3;
  localparam int CFG_DATA_W = 24;

  localparam logic [CFG_IDX_W-1:0] REG_A_X = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_A_Y = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_A_Z = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_B_X = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_B_Y = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_B_Z = 3'd5;
  localparam logic [CFG_IDX_W-1:0] REG_SCALE = 3'd6;

  // Quotient bits of the biased division, divisor width and dividend width.
  localparam int QUOT_W = 35;
  localparam int DIV_W = 59;
  localparam int NUM_W = DIV_W + QUOT_W;
  localparam int WW = 96;
  localparam int NST = 10 + QUOT_W;

  localparam logic signed [COORD_W-1:0] COORD_MAX = 24'sh7FFFFF;
  localparam logic signed [COORD_W-1:0] COORD_MIN = 24'sh800000;

  typedef logic [2:0][COORD_W-1:0] vec3_t;

  typedef struct packed {
    logic signed [COORD_W-1:0] point_x;
    logic signed [COORD_W-1:0] point_y;
    logic signed [COORD_W-1:0] point_z;
  } point_t;

  typedef struct packed {
    logic signed [COORD_W-1:0] out_x;
    logic signed [COORD_W-1:0] out_y;
    logic signed [COORD_W-1:0] out_z;
    logic                      degenerate;
  } result_t;

endpackage

[src/axial_point_scaler.sv]
// Projects each point onto the line through A and B and scales its offset from
// the foot by the scale register, all in exact fixed point with one
// round-to-nearest at the end and saturation to the 24-bit coordinate range.
// A new point is taken every cycle unless a stalled result freezes the whole
// pipeline; each one passes through eight stages of products and wide sums,
// 35 stages of a one-bit-per-stage restoring divider (one per coordinate,
// quotient biased so it is always non-negative) and two stages of add and
// saturate. Line and scale registers feed a small derived-constant pipeline
// (cab, then cden and cy, then cbias and cdeg). When A equals B the point
// passes through and degenerate is set.
module axial_point_scaler (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              point_valid,
  output logic                              point_stall,
  input  aps_pkg::point_t                   point,
  output logic                              result_valid,
  input  logic                              result_stall,
  output aps_pkg::result_t                  result,
  input  logic                              cfg_en,
  input  logic [aps_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [aps_pkg::CFG_DATA_W-1:0]    cfg_data
);
  import aps_pkg::*;

  logic signed [COORD_W-1:0] ca [3];
  logic signed [COORD_W-1:0] cb [3];
  logic signed [SCALE_W-1:0] cs;

  logic signed [24:0] cab [3];
  logic [49:0]        cden;
  logic signed [41:0] cy [3];
  logic [NUM_W-1:0]   cbias;
  logic               cdeg;
  logic [DIV_W-1:0]   cdiv;

  logic [NST-1:0] vld;
  logic           en;

  vec3_t              p_in;
  vec3_t              s1_p, s2_p, s3_p, s4_p, s5_p, s6_p, s7_p;
  logic signed [24:0] s1_ap [3];
  logic signed [49:0] s2_prod [3];
  logic signed [40:0] s2_x [3];
  logic signed [40:0] s3_x [3];
  logic signed [51:0] s3_num [3];
  logic signed [47:0] xll [3], xlh [3], xhl [3], xhh [3];
  logic signed [47:0] yll [3], ylh [3], yhl [3], yhh [3];
  logic signed [WW-1:0] tx1 [3], tx2 [3], ty1 [3], ty2 [3];
  logic signed [WW-1:0] s6_xd [3], s6_yn [3];
  logic signed [WW-1:0] s7_n [3];

  logic [DIV_W-1:0]  dr  [QUOT_W+1][3];
  logic [QUOT_W-1:0] dwq [QUOT_W+1][3];
  vec3_t             dp  [QUOT_W+1];

  vec3_t              ps;
  logic signed [36:0] ssum [3];

  assign en = !(vld[NST-1] && result_stall);
  assign point_stall = !en;
  assign result_valid = vld[NST-1];
  assign p_in = {point.point_z, point.point_y, point.point_x};

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      ca[0] <= '0;
      ca[1] <= '0;
      ca[2] <= '0;
      cb[0] <= 24'sd256;
      cb[1] <= '0;
      cb[2] <= '0;
      cs <= 16'sd256;
    end else if (cfg_en) begin
      case (cfg_index)
        REG_A_X: ca[0] <= cfg_data;
        REG_A_Y: ca[1] <= cfg_data;
        REG_A_Z: ca[2] <= cfg_data;
        REG_B_X: cb[0] <= cfg_data;
        REG_B_Y: cb[1] <= cfg_data;
        REG_B_Z: cb[2] <= cfg_data;
        REG_SCALE: cs <= cfg_data[SCALE_W-1:0];
        default: ;
      endcase
    end
  end

  // Constants derived from the line and the scale.
  always_ff @(posedge clk) begin
    logic signed [16:0] one_ms;
    logic signed [51:0] dsum;
    one_ms = 17'sd256 - 17'(cs);
    dsum = (52'(cab[0]) * 52'(cab[0])) + (52'(cab[1]) * 52'(cab[1])) +
           (52'(cab[2]) * 52'(cab[2]));
    for (int c = 0; c < 3; c++) begin
      cab[c] <= 25'(cb[c]) - 25'(ca[c]);
      cy[c] <= 42'(one_ms) * 42'(cab[c]);
    end
    cden <= dsum[49:0];
    // Rounding offset plus a bias of 2^34 divisors keeps the dividend positive.
    cbias <= (NUM_W'(cden) << 8) + (NUM_W'(cden) << 43);
    cdeg <= (cden == '0);
  end

  assign cdiv = {cden, 9'b0};

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else if (en) begin
      vld <= {vld[NST-2:0], point_valid};
    end
  end

  // Front stages: offsets, dot product, partial products and their sums.
  always_ff @(posedge clk) begin
    logic signed [21:0] xl, yl;
    logic signed [19:0] xh;
    logic signed [20:0] yh;
    logic signed [25:0] dl, dh, nl;
    logic signed [26:0] nh;
    if (en) begin
      s1_p <= p_in;
      s2_p <= s1_p;
      s3_p <= s2_p;
      s4_p <= s3_p;
      s5_p <= s4_p;
      s6_p <= s5_p;
      s7_p <= s6_p;
      dp[0] <= s7_p;
      for (int c = 0; c < 3; c++) begin
        s1_ap[c] <= 25'($signed(p_in[c])) - 25'(ca[c]);
        s2_prod[c] <= 50'(cab[c]) * 50'(s1_ap[c]);
        s2_x[c] <= 41'(cs) * 41'(s1_ap[c]);
        s3_x[c] <= s2_x[c];
        s3_num[c] <= 52'(s2_prod[0]) + 52'(s2_prod[1]) + 52'(s2_prod[2]);

        xl = $signed({1'b0, s3_x[c][20:0]});
        xh = s3_x[c][40:21];
        dl = $signed({1'b0, cden[24:0]});
        dh = $signed({1'b0, cden[49:25]});
        yl = $signed({1'b0, cy[c][20:0]});
        yh = cy[c][41:21];
        nl = $signed({1'b0, s3_num[c][24:0]});
        nh = s3_num[c][51:25];
        xll[c] <= 48'(xl) * 48'(dl);
        xlh[c] <= 48'(xl) * 48'(dh);
        xhl[c] <= 48'(xh) * 48'(dl);
        xhh[c] <= 48'(xh) * 48'(dh);
        yll[c] <= 48'(yl) * 48'(nl);
        ylh[c] <= 48'(yl) * 48'(nh);
        yhl[c] <= 48'(yh) * 48'(nl);
        yhh[c] <= 48'(yh) * 48'(nh);

        tx1[c] <= WW'(xll[c]) + (WW'(xlh[c]) <<< 25);
        tx2[c] <= WW'(xhl[c]) + (WW'(xhh[c]) <<< 25);
        ty1[c] <= WW'(yll[c]) + (WW'(ylh[c]) <<< 25);
        ty2[c] <= WW'(yhl[c]) + (WW'(yhh[c]) <<< 25);

        s6_xd[c] <= tx1[c] + (tx2[c] <<< 21);
        s6_yn[c] <= ty1[c] + (ty2[c] <<< 21);
        s7_n[c] <= s6_xd[c] + s6_yn[c];
      end
    end
  end

  // Biased dividend, split into the first partial remainder and the low bits.
  always_ff @(posedge clk) begin
    logic signed [WW-1:0] m;
    if (en) begin
      for (int c = 0; c < 3; c++) begin
        m = (s7_n[c] <<< 1) + $signed({{(WW-NUM_W){1'b0}}, cbias});
        dr[0][c] <= m[NUM_W-1:QUOT_W];
        dwq[0][c] <= m[QUOT_W-1:0];
      end
    end
  end

  for (genvar k = 0; k < QUOT_W; k++) begin : g_div
    logic [DIV_W:0] t [3];
    logic [DIV_W:0] diff [3];

    always_comb begin
      for (int c = 0; c < 3; c++) begin
        t[c] = {dr[k][c], dwq[k][c][QUOT_W-1]};
        diff[c] = t[c] - {1'b0, cdiv};
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        dp[k+1] <= dp[k];
        for (int c = 0; c < 3; c++) begin
          if (!diff[c][DIV_W]) begin
            dr[k+1][c] <= diff[c][DIV_W-1:0];
            dwq[k+1][c] <= {dwq[k][c][QUOT_W-2:0], 1'b1};
          end else begin
            dr[k+1][c] <= t[c][DIV_W-1:0];
            dwq[k+1][c] <= {dwq[k][c][QUOT_W-2:0], 1'b0};
          end
        end
      end
    end
  end

  // Remove the quotient bias, add A, then saturate; a degenerate line passes the point through.
  always_ff @(posedge clk) begin
    logic signed [36:0] q;
    logic signed [COORD_W-1:0] o [3];
    if (en) begin
      ps <= dp[QUOT_W];
      for (int c = 0; c < 3; c++) begin
        q = $signed({2'b0, dwq[QUOT_W][c]}) - 37'sh4_0000_0000;
        ssum[c] <= 37'(ca[c]) + q;
      end
      for (int c = 0; c < 3; c++) begin
        if (cdeg) begin
          o[c] = $signed(ps[c]);
        end else if (ssum[c] > 37'(COORD_MAX)) begin
          o[c] = COORD_MAX;
        end else if (ssum[c] < 37'(COORD_MIN)) begin
          o[c] = COORD_MIN;
        end else begin
          o[c] = ssum[c][COORD_W-1:0];
        end
      end
      result.out_x <= o[0];
      result.out_y <= o[1];
      result.out_z <= o[2];
      result.degenerate <= cdeg;
    end
  end

endmodule
